// ===== sv/afd_pkg.sv =====
// shared types and constants for the alarm frame deframer
package afd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  localparam logic [7:0] START_MARK = 8'h7C;
  localparam logic [7:0] END_MARK   = 8'h7E;
  localparam logic [7:0] CHECK_XOR  = 8'h8A;
  localparam logic [7:0] CMD_ALARM  = 8'h81;
  localparam logic [7:0] CMD_VER    = 8'h82;
  localparam logic [7:0] CMD_ERR    = 8'h83;
  localparam logic [7:0] CMD_UPD    = 8'h84;
  localparam logic [7:0] GPS_MARK   = 8'h41;
  localparam logic [7:0] LIM_LOW    = 8'd30;
  localparam logic [7:0] LIM_HIGH   = 8'd120;
  localparam logic [16:0] MIN_TOTAL = 17'd5;

  localparam logic [2:0] KIND_ALARM = 3'd0;
  localparam logic [2:0] KIND_VER   = 3'd1;
  localparam logic [2:0] KIND_ERR   = 3'd2;
  localparam logic [2:0] KIND_UPD   = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  // snapshot of a finished frame handed from front to back
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
    logic [7:0] p4;
    logic [7:0] p5;
  } frame_t;

  // result item
  typedef struct packed {
    logic [7:0]  error_code;
    logic [7:0]  firmware_version;
    logic [15:0] data_version;
    logic [7:0]  vehicle_speed;
    logic [15:0] distance;
    logic [7:0]  limit_speed;
    logic        speak_limit;
    logic        alarm_start;
    logic [7:0]  alarm_type;
    logic        gps_valid;
    logic [2:0]  frame_kind;
  } result_t;

endpackage

// ===== sv/afd_front.sv =====
// byte parser: hunts, checks and snapshots frames
module afd_front #(
  parameter int MAX_FRAME    = 128,
  parameter int PAYLOAD_KEEP = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic [7:0]       rx_byte,
  output logic             frame_valid,
  output afd_pkg::frame_t  frame
);

  localparam int PW = $clog2(PAYLOAD_KEEP);

  afd_pkg::phase_t phase, phase_next;
  logic [7:0]  pos;
  logic [16:0] total;
  logic [7:0]  sum;
  logic [7:0]  held;
  logic [7:0]  cmd;
  logic [7:0]  store [PAYLOAD_KEEP];
  logic [16:0] total_hi;
  logic [16:0] pos_ext;
  logic        store_hit;
  logic [7:0]  pos_off;

  assign total_hi  = {1'b0, rx_byte, total[7:0]} + 17'd2;
  assign pos_ext   = {9'd0, pos};
  assign pos_off   = pos - 8'd4;
  assign store_hit = (pos >= 8'd4) && ({1'b0, pos_off} < 9'(PAYLOAD_KEEP));

  always_comb begin
    phase_next = phase;
    case (phase)
      afd_pkg::PH_LEN_LO: phase_next = afd_pkg::PH_LEN_HI;
      afd_pkg::PH_LEN_HI: begin
        if (total_hi < afd_pkg::MIN_TOTAL || total_hi > 17'(MAX_FRAME))
          phase_next = afd_pkg::PH_HUNT;
        else
          phase_next = afd_pkg::PH_BODY;
      end
      afd_pkg::PH_BODY: begin
        if (!(pos_ext + 17'd3 <= total) && !(pos_ext + 17'd2 == total))
          phase_next = afd_pkg::PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == afd_pkg::START_MARK) ? afd_pkg::PH_LEN_LO
                                                       : afd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= afd_pkg::PH_HUNT;
      pos <= '0;
      total <= '0;
      sum <= '0;
      held <= '0;
      cmd <= '0;
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= 1'b0;
      if (byte_valid) begin
        phase <= phase_next;
        case (phase)
          afd_pkg::PH_LEN_LO: begin
            total <= {9'd0, rx_byte};
            sum <= sum + rx_byte;
            pos <= 8'd2;
          end
          afd_pkg::PH_LEN_HI: begin
            total <= total_hi;
            sum <= sum + rx_byte;
            pos <= (phase_next == afd_pkg::PH_BODY) ? 8'd3 : 8'd0;
          end
          afd_pkg::PH_BODY: begin
            if (pos == 8'd3) cmd <= rx_byte;
            if (pos_ext + 17'd3 <= total) begin
              sum <= sum + rx_byte;
              pos <= pos + 8'd1;
            end else if (pos_ext + 17'd2 == total) begin
              held <= rx_byte;
              pos <= pos + 8'd1;
            end else begin
              pos <= '0;
              frame_valid <= (rx_byte == afd_pkg::END_MARK) &&
                             (held == (sum ^ afd_pkg::CHECK_XOR));
            end
          end
          default: begin
            if (rx_byte == afd_pkg::START_MARK) begin
              pos <= 8'd1;
              sum <= '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && phase == afd_pkg::PH_BODY && store_hit)
      store[pos_off[PW-1:0]] <= rx_byte;
  end

  // store and cmd already hold the final byte's effect by the cycle frame_valid is up
  assign frame = {cmd, store[0], store[1], store[2], store[3], store[4], store[5]};

endmodule

// ===== sv/afd_back.sv =====
// decoder: turns frame snapshots into result items, keeps alarm history
module afd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_valid,
  input  afd_pkg::frame_t   frame,
  output logic              res_valid,
  output afd_pkg::result_t  res
);

  logic            eye;
  afd_pkg::result_t r;
  logic            gps;
  logic            ty_nz;

  assign gps   = frame.p0 == afd_pkg::GPS_MARK;
  assign ty_nz = frame.p1 != 8'd0;

  always_comb begin
    r = '0;
    case (frame.cmd)
      afd_pkg::CMD_ALARM: begin
        r.frame_kind = afd_pkg::KIND_ALARM;
        if (gps) begin
          r.gps_valid = 1'b1;
          if (ty_nz) begin
            r.alarm_type    = frame.p1;
            r.alarm_start   = !eye;
            r.speak_limit   = frame.p2 >= afd_pkg::LIM_LOW && frame.p2 <= afd_pkg::LIM_HIGH &&
                              (frame.p1 inside {8'd2, 8'd3, 8'd4, 8'd18});
            r.limit_speed   = frame.p2;
            r.distance      = {frame.p4, frame.p3};
            r.vehicle_speed = frame.p5;
          end
        end
      end
      afd_pkg::CMD_VER: begin
        r.frame_kind = afd_pkg::KIND_VER;
        r.data_version = {frame.p1, frame.p0};
        r.firmware_version = frame.p2;
      end
      afd_pkg::CMD_ERR: begin
        r.frame_kind = afd_pkg::KIND_ERR;
        r.error_code = frame.p0;
      end
      afd_pkg::CMD_UPD: r.frame_kind = afd_pkg::KIND_UPD;
      default: r.frame_kind = afd_pkg::KIND_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eye <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= frame_valid;
      if (frame_valid && frame.cmd == afd_pkg::CMD_ALARM && gps)
        eye <= ty_nz;
    end
  end

  always_ff @(posedge clk) begin
    res <= r;
  end

endmodule

// ===== sv/afd_queue.sv =====
// small result queue between decoder and output port
module afd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  afd_pkg::result_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output afd_pkg::result_t             out_data,
  output logic [$clog2(DEPTH):0]       level
);

  localparam int AW = $clog2(DEPTH);

  afd_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (in_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(in_valid) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) mem[wr_ptr] <= in_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == (AW+1)'(DEPTH)) |-> !in_valid)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !pop) |=> count == $past(count) + 1'b1)
    else $error("count did not grow");

endmodule

// ===== sv/alarm_frame_deframer.sv =====
// top level of the alarm frame deframer
// usage:
//   s_axis carries received bytes, one item per byte, tdata[7:0] = rx_byte
//   m_axis carries one result item per valid frame, fields packed in tdata
//   the parser takes a byte every cycle while s_axis_tready is high, so bytes
//   may follow back to back; after the edge that accepts the end marker a result
//   passes the decode register and the queue write before m_axis_tvalid rises
//   throughput: one byte per cycle while s_axis_tready is high, set by the parse step
//   results wait in a four-entry queue; s_axis_tready drops while queued
//   results plus those still in the check and decode stages fill it,
//   since the byte taken next may close a frame
//   with the receiver ready the queue never holds more than one result, so
//   input is held off only while the receiver stalls
//   reset clears parser state, alarm history and the queue; the payload
//   store holds whatever it had until written again
//   a frame that fails length, checksum or end marker checks is dropped
//   and hunting resumes with the next byte
module alarm_frame_deframer #(
  parameter int MAX_FRAME    = 128,
  parameter int PAYLOAD_KEEP = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // frame_kind, gps_valid, alarm_type, alarm_start,
                                      // speak_limit, limit_speed, distance, vehicle_speed,
                                      // data_version, firmware_version, error_code, pad
);

  localparam int QDEPTH = 4;

  logic             byte_valid;
  logic             frame_valid;
  afd_pkg::frame_t  frame;
  logic             res_valid;
  afd_pkg::result_t res, q_out;
  logic [2:0]       q_level;
  logic             q_has;

  assign byte_valid    = s_axis_tvalid && s_axis_tready;
  // every result already on its way needs a queue slot, plus one for this byte
  assign s_axis_tready = (q_level + 3'(frame_valid) + 3'(res_valid)) < 3'(QDEPTH);

  afd_front #(.MAX_FRAME(MAX_FRAME), .PAYLOAD_KEEP(PAYLOAD_KEEP)) u_front (
    .clk, .rst, .byte_valid, .rx_byte(s_axis_tdata), .frame_valid, .frame
  );

  afd_back u_back (.clk, .rst, .frame_valid, .frame, .res_valid, .res);

  afd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst, .in_valid(res_valid), .in_data(res),
    .out_valid(q_has), .out_ready(m_axis_tready), .out_data(q_out), .level(q_level)
  );

  assign m_axis_tvalid = q_has;
  assign m_axis_tdata  = {{(80-$bits(afd_pkg::result_t)){1'b0}}, q_out};

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the alarm frame deframer
`timescale 1ns / 100ps

module tb_top;

  localparam int MAXF      = 128;
  localparam int KEEP      = 16;
  localparam int PAY_OFS   = 4;
  localparam int LIMIT     = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  // predicted parser state
  afd_pkg::phase_t ph = afd_pkg::PH_HUNT;
  logic [7:0]  pos = '0;
  logic [16:0] total = '0;
  logic [7:0]  sum = '0;
  logic [7:0]  held = '0;
  logic [7:0]  store [KEEP];
  logic        eye = 1'b0;
  logic [7:0]  cmd = '0;

  afd_pkg::result_t pending_results [$];
  int          fails = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;   // no idling on either side

  alarm_frame_deframer dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] pay(int k);
    return store[k];
  endfunction

  // decode the finished frame from the command register and the store
  function automatic afd_pkg::result_t decode_frame();
    afd_pkg::result_t r;
    logic [7:0] ty, lim;
    r = '0;
    case (cmd)
      afd_pkg::CMD_ALARM: begin
        r.frame_kind = afd_pkg::KIND_ALARM;
        if (pay(0) == afd_pkg::GPS_MARK) begin
          ty = pay(1);
          r.gps_valid = 1'b1;
          if (ty != 8'd0) begin
            lim = pay(2);
            r.alarm_type    = ty;
            r.alarm_start   = !eye;
            eye             = 1'b1;
            r.speak_limit   = lim >= afd_pkg::LIM_LOW && lim <= afd_pkg::LIM_HIGH &&
                              (ty == 8'd2 || ty == 8'd3 || ty == 8'd4 || ty == 8'd18);
            r.limit_speed   = lim;
            r.distance      = {pay(4), pay(3)};
            r.vehicle_speed = pay(5);
          end else begin
            eye = 1'b0;
          end
        end
      end
      afd_pkg::CMD_VER: begin
        r.frame_kind       = afd_pkg::KIND_VER;
        r.data_version     = {pay(1), pay(0)};
        r.firmware_version = pay(2);
      end
      afd_pkg::CMD_ERR: begin
        r.frame_kind = afd_pkg::KIND_ERR;
        r.error_code = pay(0);
      end
      afd_pkg::CMD_UPD: r.frame_kind = afd_pkg::KIND_UPD;
      default: r.frame_kind = afd_pkg::KIND_OTHER;
    endcase
    return r;
  endfunction

  // one accepted byte through the predicted parser
  function automatic void deframe_byte(logic [7:0] b);
    case (ph)
      afd_pkg::PH_LEN_LO: begin
        total = {9'd0, b};
        sum   = sum + b;
        ph    = afd_pkg::PH_LEN_HI;
        pos   = 8'd2;
      end
      afd_pkg::PH_LEN_HI: begin
        total = (total | {1'b0, b, 8'd0}) + 17'd2;
        sum   = sum + b;
        if (total < afd_pkg::MIN_TOTAL || total > MAXF) begin
          ph  = afd_pkg::PH_HUNT;
          pos = 8'd0;
        end else begin
          ph  = afd_pkg::PH_BODY;
          pos = 8'd3;
        end
      end
      afd_pkg::PH_BODY: begin
        if (pos == 8'd3) cmd = b;
        if (pos >= PAY_OFS && pos - PAY_OFS < KEEP) store[pos - PAY_OFS] = b;
        if (pos + 17'd3 <= total) begin
          sum = sum + b;
          pos = pos + 8'd1;
        end else if (pos + 17'd2 == total) begin
          held = b;
          pos  = pos + 8'd1;
        end else begin
          ph  = afd_pkg::PH_HUNT;
          pos = 8'd0;
          if (b == afd_pkg::END_MARK && held == (sum ^ afd_pkg::CHECK_XOR))
            pending_results.push_back(decode_frame());
        end
      end
      default: begin
        ph = afd_pkg::PH_HUNT;
        if (b == afd_pkg::START_MARK) begin
          ph  = afd_pkg::PH_LEN_LO;
          pos = 8'd1;
          sum = 8'd0;
        end
      end
    endcase
  endfunction

  task automatic check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    afd_pkg::result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = afd_pkg::result_t'(m_axis_tdata[$bits(afd_pkg::result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result item with none expected");
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_kind", want.frame_kind, got.frame_kind);
        check_field("gps_valid", want.gps_valid, got.gps_valid);
        check_field("alarm_type", want.alarm_type, got.alarm_type);
        check_field("alarm_start", want.alarm_start, got.alarm_start);
        check_field("speak_limit", want.speak_limit, got.speak_limit);
        check_field("limit_speed", want.limit_speed, got.limit_speed);
        check_field("distance", want.distance, got.distance);
        check_field("vehicle_speed", want.vehicle_speed, got.vehicle_speed);
        check_field("data_version", want.data_version, got.data_version);
        check_field("firmware_version", want.firmware_version, got.firmware_version);
        check_field("error_code", want.error_code, got.error_code);
      end
    end
  end

  // drive one byte and wait for it to be taken, then maybe idle a burst
  task automatic send_byte(logic [7:0] b);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    deframe_byte(b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // frame from its body (command byte onward), with optional damage
  task automatic send_frame(logic [7:0] body [$], bit bad_sum = 0, bit bad_end = 0);
    logic [15:0] len;
    logic [7:0]  s;
    len = 16'(body.size() + 3);
    s   = len[7:0] + len[15:8];
    foreach (body[i]) s += body[i];
    s ^= afd_pkg::CHECK_XOR;
    if (bad_sum) s ^= 8'(1 << $urandom_range(0, 7));
    send_byte(afd_pkg::START_MARK);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (body[i]) send_byte(body[i]);
    send_byte(s);
    send_byte(bad_end ? 8'h7D : afd_pkg::END_MARK);
  endtask

  task automatic send_alarm(logic [7:0] gps, logic [7:0] ty, logic [7:0] lim);
    send_frame('{afd_pkg::CMD_ALARM, gps, ty, lim, 8'($urandom), 8'($urandom),
                 8'($urandom)});
  endtask

  // hold the sender until every predicted result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] fill [$];
    // fill the whole payload store first so no read ever sees an unwritten entry
    fill = {afd_pkg::CMD_VER};
    repeat (22) fill.push_back(8'($urandom));
    send_frame(fill);
    send_frame('{afd_pkg::CMD_VER, 8'hFF, 8'h00, 8'hFF});
    send_frame('{afd_pkg::CMD_ERR, 8'h00});
    send_frame('{afd_pkg::CMD_ERR, 8'hFF});
    send_frame('{afd_pkg::CMD_UPD});
    send_frame('{8'h00});
    send_frame('{8'hFF, 8'h12});
    fill = {};
    send_frame(fill);                      // shortest frame, check byte is command
    send_alarm(8'h42, 8'd2, 8'd50);        // alarm without gps mark
    send_alarm(afd_pkg::GPS_MARK, 8'd18, 8'd29);    // alarm start
    send_alarm(afd_pkg::GPS_MARK, 8'd18, 8'd30);    // alarm still present
    send_alarm(afd_pkg::GPS_MARK, 8'd2, 8'd120);
    send_alarm(afd_pkg::GPS_MARK, 8'd3, 8'd121);
    send_alarm(afd_pkg::GPS_MARK, 8'd0, 8'd60);     // alarm cleared
    send_alarm(afd_pkg::GPS_MARK, 8'd4, 8'd255);
    send_frame('{afd_pkg::CMD_ALARM, afd_pkg::GPS_MARK});  // short alarm reads older payload
    send_frame('{afd_pkg::CMD_ERR, 8'h33}, 1'b1, 1'b0);
    send_frame('{afd_pkg::CMD_ERR, 8'h33}, 1'b0, 1'b1);
    // length too short, too long, and high byte set
    send_byte(afd_pkg::START_MARK); send_byte(8'd2); send_byte(8'd0);
    send_byte(afd_pkg::START_MARK); send_byte(8'd127); send_byte(8'd0);
    send_byte(afd_pkg::START_MARK); send_byte(8'hFF); send_byte(8'hFF);
    fill = {afd_pkg::CMD_UPD};
    repeat (122) fill.push_back(8'($urandom));
    send_frame(fill);                      // longest allowed frame
    drain();
  endtask

  task automatic test_random(int items);
    logic [7:0] body [$];
    int sent, n, pick;
    logic [7:0] ty;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte($urandom_range(0, 3) == 0 ? afd_pkg::START_MARK
                                                       : 8'($urandom));
        sent += n;
      end else begin
        body = {};
        case ($urandom_range(0, 5))
          0, 1: begin
            case ($urandom_range(0, 4))
              0: ty = 8'd0;
              1: ty = 8'd2;
              2: ty = 8'd18;
              3: ty = 8'($urandom_range(3, 4));
              default: ty = 8'($urandom);
            endcase
            body = {afd_pkg::CMD_ALARM,
                    ($urandom_range(0, 4) != 0) ? afd_pkg::GPS_MARK : 8'($urandom), ty,
                    8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(28, 122))};
          end
          2: body = {afd_pkg::CMD_VER};
          3: body = {afd_pkg::CMD_ERR};
          4: body = {afd_pkg::CMD_UPD};
          default: body = {8'($urandom)};
        endcase
        n = ($urandom_range(0, 20) == 0) ? $urandom_range(0, 118) : $urandom_range(0, 8);
        repeat (n) body.push_back(8'($urandom));
        if ($urandom_range(0, 6) == 0) body = body[0:$urandom_range(0, body.size() - 1)];
        pick = $urandom_range(0, 11);
        send_frame(body, pick == 0, pick == 1);
        sent += body.size() + 5;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(900);
    drain();
    test_random(250);
    quiet = 1'b1;
    test_random(100);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
